/* sv/msp_pkg.sv */
// shared constants, types and register codes of the motor speed pi core
package msp_pkg;

    localparam int SPEED_BITS = 12;

    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 10;
    localparam int TIME_W   = 16;
    localparam int THR_W    = 11;
    localparam int ACC_W    = 11;
    localparam int LAMP_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SP_W      = SPEED_BITS + 1;
    localparam int ERR_W     = SPEED_BITS + 1;
    localparam int D_W       = ERR_W + 1;
    localparam int SUM_W     = SPEED_BITS + 4;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_SHIFT = MAG_W + 4;
    localparam int PROD_W    = D_W + GAIN_W + 2;
    localparam int INC_W     = PROD_W - 8;
    localparam int ASUM_W    = INC_W + 1;
    localparam int CMP_W     = (SPEED_BITS > THR_W) ? SPEED_BITS + 1 : THR_W + 1;

    localparam logic [MAG_W:0] DIV_RECIP = (MAG_W + 1)'((64'd1 << DIV_SHIFT) / 64'd10);
    localparam logic [MAG_W-1:0] DIV_TEN = MAG_W'(10);
    localparam logic [LAMP_W-1:0] LAMP_MAX = LAMP_W'(10);
    localparam logic signed [PROD_W-1:0] TRUNC_ADJ = PROD_W'(255);

    localparam logic [GAIN_W-1:0] RST_PROP_GAIN    = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] RST_INT_GAIN     = GAIN_W'(0);
    localparam logic [DUTY_W-1:0] RST_DUTY_LIMIT   = DUTY_W'(990);
    localparam logic [DUTY_W-1:0] RST_LAUNCH_DUTY  = DUTY_W'(800);
    localparam logic [TIME_W-1:0] RST_LAUNCH_START = TIME_W'(300);
    localparam logic [TIME_W-1:0] RST_LAUNCH_END   = TIME_W'(400);
    localparam logic [THR_W-1:0]  RST_LAUNCH_SPEED = THR_W'(80);
    localparam logic [THR_W-1:0]  RST_STOP_SPEED   = THR_W'(20);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INT_GAIN     = 3'd1,
        CFG_DUTY_LIMIT   = 3'd2,
        CFG_LAUNCH_DUTY  = 3'd3,
        CFG_LAUNCH_START = 3'd4,
        CFG_LAUNCH_END   = 3'd5,
        CFG_LAUNCH_SPEED = 3'd6,
        CFG_STOP_SPEED   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_HOLD     = 3'd0,
        MODE_STOP_CUT = 3'd1,
        MODE_STOP_PI  = 3'd2,
        MODE_LAUNCH   = 3'd3,
        MODE_IDLE     = 3'd4,
        MODE_REGULATE = 3'd5
    } t_mode;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] int_gain;
        logic [DUTY_W-1:0] duty_limit;
        logic [DUTY_W-1:0] launch_duty;
        logic [TIME_W-1:0] launch_start;
        logic [TIME_W-1:0] launch_end;
        logic [THR_W-1:0]  launch_speed;
        logic [THR_W-1:0]  stop_speed;
    } t_cfg;

    typedef struct packed {
        logic signed [SP_W-1:0]       setpoint;
        logic signed [SPEED_BITS-1:0] measured;
        t_mode                        mode;
    } t_stage;

endpackage

/* sv/msp_smooth.sv */
// setpoint history, smoothing filter with divide by ten, and mode decode
module msp_smooth (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic                                i_advance,
    input  logic signed [msp_pkg::SPEED_BITS-1:0] i_target_speed,
    input  logic signed [msp_pkg::SPEED_BITS-1:0] i_measured_speed,
    input  logic                                i_stop_request,
    input  logic [msp_pkg::TIME_W-1:0]          i_run_time,
    input  msp_pkg::t_cfg                       i_cfg,
    output msp_pkg::t_stage                     o_stage
);

    logic signed [msp_pkg::SPEED_BITS-1:0] r_hist0;
    logic signed [msp_pkg::SPEED_BITS-1:0] r_hist1;
    logic signed [msp_pkg::SUM_W-1:0]      r_sum;
    logic signed [msp_pkg::SUM_W-1:0]      n_sum;
    logic signed [msp_pkg::SPEED_BITS-1:0] r_meas;
    logic                                  r_stop;
    logic [msp_pkg::TIME_W-1:0]            r_time;
    msp_pkg::t_stage                       r_stage;
    msp_pkg::t_stage                       n_stage;

    logic [msp_pkg::MAG_W-1:0]     mag;
    logic [2*msp_pkg::MAG_W:0]     prod;
    logic [msp_pkg::MAG_W-1:0]     q_est;
    logic [msp_pkg::MAG_W-1:0]     rem;
    logic [msp_pkg::MAG_W-1:0]     quot;
    logic signed [msp_pkg::SP_W-1:0] sp_mag;
    logic signed [msp_pkg::SP_W-1:0] setpoint;
    logic signed [msp_pkg::CMP_W-1:0] meas_x;
    logic below_stop;
    logic below_launch;
    logic in_window;
    logic past_window;

    // 7*x0 + 2*x1 + x2
    assign n_sum = (msp_pkg::SUM_W'(i_target_speed) <<< 3) - msp_pkg::SUM_W'(i_target_speed)
                 + (msp_pkg::SUM_W'(r_hist0) <<< 1) + msp_pkg::SUM_W'(r_hist1);

    // truncating divide by ten through the reciprocal, one correction step
    always_comb begin
        mag    = r_sum[msp_pkg::SUM_W-1] ? msp_pkg::MAG_W'(-r_sum) : msp_pkg::MAG_W'(r_sum);
        prod   = (2*msp_pkg::MAG_W+1)'(mag) * (2*msp_pkg::MAG_W+1)'(msp_pkg::DIV_RECIP);
        q_est  = msp_pkg::MAG_W'(prod >> msp_pkg::DIV_SHIFT);
        rem    = mag - ((q_est << 3) + (q_est << 1));
        quot   = (rem >= msp_pkg::DIV_TEN) ? q_est + msp_pkg::MAG_W'(1) : q_est;
        sp_mag = $signed(msp_pkg::SP_W'(quot));
        setpoint = r_sum[msp_pkg::SUM_W-1] ? -sp_mag : sp_mag;
    end

    always_comb begin
        meas_x       = msp_pkg::CMP_W'(r_meas);
        below_stop   = meas_x < $signed(msp_pkg::CMP_W'(i_cfg.stop_speed));
        below_launch = meas_x < $signed(msp_pkg::CMP_W'(i_cfg.launch_speed));
        in_window    = (r_time > i_cfg.launch_start) && (r_time <= i_cfg.launch_end);
        past_window  = r_time > i_cfg.launch_end;

        n_stage.setpoint = setpoint;
        n_stage.measured = r_meas;
        n_stage.mode     = msp_pkg::MODE_HOLD;
        if (r_stop) begin
            n_stage.setpoint = '0;
            n_stage.mode     = below_stop ? msp_pkg::MODE_STOP_CUT : msp_pkg::MODE_STOP_PI;
        end else if (in_window && below_launch) begin
            n_stage.mode = msp_pkg::MODE_LAUNCH;
        end else if (past_window) begin
            n_stage.mode = below_launch ? msp_pkg::MODE_IDLE : msp_pkg::MODE_REGULATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist0 <= '0;
            r_hist1 <= '0;
        end else if (i_load) begin
            r_hist0 <= i_target_speed;
            r_hist1 <= r_hist0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum  <= n_sum;
            r_meas <= i_measured_speed;
            r_stop <= i_stop_request;
            r_time <= i_run_time;
        end
        if (i_advance) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

/* sv/msp_pi.sv */
// incremental pi update, duty clamp, launch and stop handling, held outputs
module msp_pi (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  msp_pkg::t_stage            i_stage,
    input  msp_pkg::t_cfg              i_cfg,
    output logic [msp_pkg::DUTY_W-1:0] o_forward_duty,
    output logic [msp_pkg::DUTY_W-1:0] o_reverse_duty,
    output logic                       o_drive_written,
    output logic                       o_lamp_on
);

    logic signed [msp_pkg::ERR_W-1:0]  r_prev_err;
    logic signed [msp_pkg::ACC_W-1:0]  r_acc;
    logic [msp_pkg::LAMP_W-1:0]        r_lamp_cnt;
    logic [msp_pkg::DUTY_W-1:0]        r_fwd;
    logic [msp_pkg::DUTY_W-1:0]        r_rev;
    logic                              r_lamp;
    logic                              r_written;

    logic signed [msp_pkg::ERR_W-1:0]  n_prev_err;
    logic signed [msp_pkg::ACC_W-1:0]  n_acc;
    logic [msp_pkg::LAMP_W-1:0]        n_lamp_cnt;
    logic [msp_pkg::DUTY_W-1:0]        n_fwd;
    logic [msp_pkg::DUTY_W-1:0]        n_rev;
    logic                              n_lamp;
    logic                              n_written;

    logic signed [msp_pkg::ERR_W-1:0]  err;
    logic signed [msp_pkg::D_W-1:0]    derr;
    logic signed [msp_pkg::PROD_W-1:0] p_term;
    logic signed [msp_pkg::PROD_W-1:0] i_term;
    logic signed [msp_pkg::PROD_W-1:0] num;
    logic signed [msp_pkg::PROD_W-1:0] num_adj;
    logic signed [msp_pkg::INC_W-1:0]  inc;
    logic signed [msp_pkg::ASUM_W-1:0] asum;
    logic signed [msp_pkg::ASUM_W-1:0] lim;
    logic signed [msp_pkg::ASUM_W-1:0] clamped;
    logic signed [msp_pkg::ACC_W-1:0]  pi_acc;
    logic [msp_pkg::DUTY_W-1:0]        pi_fwd;
    logic [msp_pkg::DUTY_W-1:0]        pi_rev;
    logic [msp_pkg::LAMP_W-1:0]        lamp_inc;

    always_comb begin
        err  = i_stage.setpoint - msp_pkg::ERR_W'(i_stage.measured);
        derr = msp_pkg::D_W'(err) - msp_pkg::D_W'(r_prev_err);
        p_term = msp_pkg::PROD_W'($signed({1'b0, i_cfg.prop_gain})) * msp_pkg::PROD_W'(derr);
        i_term = msp_pkg::PROD_W'($signed({1'b0, i_cfg.int_gain})) * msp_pkg::PROD_W'(err);
        num     = p_term + i_term;
        // round toward zero on the divide by 256
        num_adj = num + (num[msp_pkg::PROD_W-1] ? msp_pkg::TRUNC_ADJ : '0);
        inc     = msp_pkg::INC_W'(num_adj >>> 8);
        asum    = msp_pkg::ASUM_W'(r_acc) + msp_pkg::ASUM_W'(inc);
        lim     = $signed(msp_pkg::ASUM_W'(i_cfg.duty_limit));
        if (asum >= lim) begin
            clamped = lim;
        end else if (asum <= -lim) begin
            clamped = -lim;
        end else begin
            clamped = asum;
        end
        pi_acc = msp_pkg::ACC_W'(clamped);
        if (pi_acc[msp_pkg::ACC_W-1]) begin
            pi_fwd = '0;
            pi_rev = msp_pkg::DUTY_W'(-pi_acc);
        end else begin
            pi_fwd = msp_pkg::DUTY_W'(pi_acc);
            pi_rev = '0;
        end
    end

    always_comb begin
        n_prev_err = r_prev_err;
        n_acc      = r_acc;
        n_lamp_cnt = r_lamp_cnt;
        n_fwd      = r_fwd;
        n_rev      = r_rev;
        n_lamp     = r_lamp;
        n_written  = 1'b1;
        lamp_inc   = r_lamp_cnt + msp_pkg::LAMP_W'(1);

        if (i_stage.mode == msp_pkg::MODE_STOP_CUT || i_stage.mode == msp_pkg::MODE_STOP_PI) begin
            if (lamp_inc < msp_pkg::LAMP_MAX) begin
                n_lamp_cnt = lamp_inc;
                n_lamp     = 1'b1;
            end else begin
                n_lamp_cnt = msp_pkg::LAMP_MAX;
                n_lamp     = 1'b0;
            end
        end

        case (i_stage.mode) inside
            msp_pkg::MODE_STOP_CUT, msp_pkg::MODE_IDLE: begin
                n_fwd = '0;
                n_rev = '0;
            end
            msp_pkg::MODE_STOP_PI, msp_pkg::MODE_REGULATE: begin
                n_prev_err = err;
                n_acc      = pi_acc;
                n_fwd      = pi_fwd;
                n_rev      = pi_rev;
            end
            msp_pkg::MODE_LAUNCH: begin
                n_fwd = i_cfg.launch_duty;
                n_rev = '0;
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_acc      <= '0;
            r_lamp_cnt <= '0;
            r_fwd      <= '0;
            r_rev      <= '0;
            r_lamp     <= 1'b0;
            r_written  <= 1'b0;
        end else if (i_advance) begin
            r_prev_err <= n_prev_err;
            r_acc      <= n_acc;
            r_lamp_cnt <= n_lamp_cnt;
            r_fwd      <= n_fwd;
            r_rev      <= n_rev;
            r_lamp     <= n_lamp;
            r_written  <= n_written;
        end
    end

    assign o_forward_duty  = r_fwd;
    assign o_reverse_duty  = r_rev;
    assign o_drive_written = r_written;
    assign o_lamp_on       = r_lamp;

endmodule

/* sv/motor_speed_pi_with_launch_and_stop_core.sv */
// top level: config registers, three stage pipeline control, filter and pi stages
// path: an input is registered in the filter input registers, then the stage register, then the output registers
// throughput: one item per cycle while the output is not stalled; the pi accumulator loop closes in the last stage
// the input side keeps taking items while a result waits, until all stages are full
// reset: synchronous active low; clears the pipeline, history, pi state and held
// duties, and loads the register defaults
module motor_speed_pi_with_launch_and_stop_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [msp_pkg::SPEED_BITS-1:0] i_target_speed,
    input  logic signed [msp_pkg::SPEED_BITS-1:0] i_measured_speed,
    input  logic                                  i_stop_request,
    input  logic [msp_pkg::TIME_W-1:0]            i_run_time,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [msp_pkg::DUTY_W-1:0]            o_forward_duty,
    output logic [msp_pkg::DUTY_W-1:0]            o_reverse_duty,
    output logic                                  o_drive_written,
    output logic                                  o_lamp_on,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    msp_pkg::t_cfg   r_cfg;
    msp_pkg::t_stage stage;

    logic r_a_valid;
    logic r_b_valid;
    logic r_out_valid;
    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic in_xfer;
    logic a_xfer;
    logic b_xfer;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign b_ready   = !r_b_valid || out_ready;
    assign a_ready   = !r_a_valid || b_ready;
    assign in_xfer   = i_in_valid && a_ready;
    assign a_xfer    = r_a_valid && b_ready;
    assign b_xfer    = r_b_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= msp_pkg::RST_PROP_GAIN;
            r_cfg.int_gain     <= msp_pkg::RST_INT_GAIN;
            r_cfg.duty_limit   <= msp_pkg::RST_DUTY_LIMIT;
            r_cfg.launch_duty  <= msp_pkg::RST_LAUNCH_DUTY;
            r_cfg.launch_start <= msp_pkg::RST_LAUNCH_START;
            r_cfg.launch_end   <= msp_pkg::RST_LAUNCH_END;
            r_cfg.launch_speed <= msp_pkg::RST_LAUNCH_SPEED;
            r_cfg.stop_speed   <= msp_pkg::RST_STOP_SPEED;
        end else if (i_cfg_valid) begin
            unique case (msp_pkg::t_cfg_idx'(i_cfg_index))
                msp_pkg::CFG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data;
                msp_pkg::CFG_INT_GAIN:     r_cfg.int_gain     <= i_cfg_data;
                msp_pkg::CFG_DUTY_LIMIT:   r_cfg.duty_limit   <= i_cfg_data[msp_pkg::DUTY_W-1:0];
                msp_pkg::CFG_LAUNCH_DUTY:  r_cfg.launch_duty  <= i_cfg_data[msp_pkg::DUTY_W-1:0];
                msp_pkg::CFG_LAUNCH_START: r_cfg.launch_start <= i_cfg_data;
                msp_pkg::CFG_LAUNCH_END:   r_cfg.launch_end   <= i_cfg_data;
                msp_pkg::CFG_LAUNCH_SPEED: r_cfg.launch_speed <= i_cfg_data[msp_pkg::THR_W-1:0];
                msp_pkg::CFG_STOP_SPEED:   r_cfg.stop_speed   <= i_cfg_data[msp_pkg::THR_W-1:0];
            endcase
        end
    end

    msp_smooth u_smooth (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (in_xfer),
        .i_advance        (a_xfer),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .i_stop_request   (i_stop_request),
        .i_run_time       (i_run_time),
        .i_cfg            (r_cfg),
        .o_stage          (stage)
    );

    msp_pi u_pi (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (b_xfer),
        .i_stage         (stage),
        .i_cfg           (r_cfg),
        .o_forward_duty  (o_forward_duty),
        .o_reverse_duty  (o_reverse_duty),
        .o_drive_written (o_drive_written),
        .o_lamp_on       (o_lamp_on)
    );

    assign o_in_stall  = !a_ready;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

endmodule

/* sv/msp_checker.sv */
// port level checker for the motor speed pi core and its bind
module msp_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic signed [msp_pkg::SPEED_BITS-1:0] i_target_speed,
    input logic signed [msp_pkg::SPEED_BITS-1:0] i_measured_speed,
    input logic                                  i_stop_request,
    input logic [msp_pkg::TIME_W-1:0]            i_run_time,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic [msp_pkg::DUTY_W-1:0]            o_forward_duty,
    input logic [msp_pkg::DUTY_W-1:0]            o_reverse_duty,
    input logic                                  o_drive_written,
    input logic                                  o_lamp_on,
    input logic                                  i_cfg_valid,
    input logic                                  o_cfg_ready,
    input logic [msp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input logic [msp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // the motor is never driven both ways at once
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forward_duty == '0 || o_reverse_duty == '0))
        else $error("forward and reverse duty both nonzero");

    // with no result pending the pipeline has room
    a_room_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_forward_duty)
            && $stable(o_reverse_duty) && $stable(o_drive_written) && $stable(o_lamp_on))
        else $error("stalled result changed");

endmodule

bind motor_speed_pi_with_launch_and_stop_core msp_checker u_msp_checker (.*);

/* test/tb.sv */
// self-checking testbench of the motor speed pi core: directed table, then random settings
`timescale 1ns / 1ps

module tb;
    import msp_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int DIR_ROWS     = 25;
    localparam int RAND_PHASES  = 8;

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
        logic              written;
        logic              lamp;
    } drive_t;

    typedef struct {
        int phase;
        int target;
        int measured;
        bit stop;
        int run_time;
        bit known;
        int fwd;
        int rev;
        bit written;
        bit lamp;
    } step_row_t;

    typedef enum int {
        SET_TYPICAL,
        SET_MAXED,
        SET_ZERO,
        SET_EMPTY_WIN,
        SET_RANDOM,
        SET_ALL_LAUNCH
    } setting_t;

    logic                         i_clk;
    logic                         i_rst_n          = 1'b0;
    logic                         i_in_valid       = 1'b0;
    logic                         o_in_stall;
    logic signed [SPEED_BITS-1:0] i_target_speed   = '0;
    logic signed [SPEED_BITS-1:0] i_measured_speed = '0;
    logic                         i_stop_request   = 1'b0;
    logic [TIME_W-1:0]            i_run_time       = '0;
    logic                         o_out_valid;
    logic                         i_out_stall      = 1'b0;
    logic [DUTY_W-1:0]            o_forward_duty;
    logic [DUTY_W-1:0]            o_reverse_duty;
    logic                         o_drive_written;
    logic                         o_lamp_on;
    logic                         i_cfg_valid      = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data       = '0;

    motor_speed_pi_with_launch_and_stop_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .i_stop_request   (i_stop_request),
        .i_run_time       (i_run_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_forward_duty   (o_forward_duty),
        .o_reverse_duty   (o_reverse_duty),
        .o_drive_written  (o_drive_written),
        .o_lamp_on        (o_lamp_on),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // controller state mirrored by the predictor
    t_cfg drv_cfg = '{RST_PROP_GAIN, RST_INT_GAIN, RST_DUTY_LIMIT, RST_LAUNCH_DUTY,
                      RST_LAUNCH_START, RST_LAUNCH_END, RST_LAUNCH_SPEED, RST_STOP_SPEED};
    int                sp_hist0   = 0;
    int                sp_hist1   = 0;
    int                last_err   = 0;
    int                duty_acc   = 0;
    int                lamp_count = 0;
    logic [DUTY_W-1:0] fwd_hold   = '0;
    logic [DUTY_W-1:0] rev_hold   = '0;
    logic              lamp_hold  = 1'b0;

    drive_t drive_queue[$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_seen    = 0;
    int  settings_loaded = 0;
    int  cycle_count     = 0;
    int  stall_left      = 0;
    int  stop_burst      = 0;
    int  cur_target      = 0;
    bit  in_idle_on      = 1'b1;
    bit  out_stall_on    = 1'b1;

    t_cfg dir_cfg [3] = '{
        '{prop_gain: RST_PROP_GAIN, int_gain: RST_INT_GAIN, duty_limit: RST_DUTY_LIMIT,
          launch_duty: RST_LAUNCH_DUTY, launch_start: RST_LAUNCH_START,
          launch_end: RST_LAUNCH_END, launch_speed: RST_LAUNCH_SPEED,
          stop_speed: RST_STOP_SPEED},
        '{prop_gain: '1, int_gain: '1, duty_limit: '1, launch_duty: '1,
          launch_start: 16'd500, launch_end: 16'd500, launch_speed: '0, stop_speed: '0},
        '{prop_gain: 16'd256, int_gain: 16'd256, duty_limit: '0, launch_duty: '0,
          launch_start: '0, launch_end: '0, launch_speed: '0, stop_speed: '0}
    };

    step_row_t dir_rows [DIR_ROWS] = '{
        '{0,     0,     0, 0,     0, 1,   0, 0, 0, 0},
        '{0,  2047,     0, 0,   350, 1, 800, 0, 1, 0},
        '{0, -2048,   100, 0,   301, 1, 800, 0, 0, 0},
        '{0,   100,    79, 0,   400, 1, 800, 0, 1, 0},
        '{0,   100,    10, 0,   401, 1,   0, 0, 1, 0},
        '{0,  2047,  2047, 0, 65535, 1,   0, 0, 1, 0},
        '{0,     0, -2048, 1,     0, 1,   0, 0, 1, 1},
        '{0,     0,  2047, 1,     0, 1,   0, 0, 1, 1},
        '{0,     0,    19, 1,     0, 1,   0, 0, 1, 1},
        '{0,     0,     0, 0,     0, 1,   0, 0, 0, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 1},
        '{0, -2048,    20, 1, 65535, 1,   0, 0, 1, 0},
        '{1,  2047, -2048, 0,   500, 0,   0, 0, 0, 0},
        '{1,  2047,     0, 0, 65535, 0,   0, 0, 0, 0},
        '{1,  2047,     0, 0, 60000, 0,   0, 0, 0, 0},
        '{1, -2048,  2047, 0,  1000, 0,   0, 0, 0, 0},
        '{1,     0,    -1, 1,     0, 0,   0, 0, 0, 0},
        '{1,     0,     0, 1,     0, 0,   0, 0, 0, 0},
        '{2,  2047,     0, 0,     1, 1,   0, 0, 1, 0},
        '{2, -2048,  2047, 0, 65535, 1,   0, 0, 1, 0}
    };

    setting_t plan [RAND_PHASES] = '{SET_TYPICAL, SET_RANDOM, SET_MAXED, SET_EMPTY_WIN,
                                     SET_ZERO, SET_ALL_LAUNCH, SET_TYPICAL, SET_RANDOM};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void pi_step(int setpoint, int meas);
        longint err, diff, incr, acc, lim, kp, ki;
        kp   = drv_cfg.prop_gain;
        ki   = drv_cfg.int_gain;
        lim  = drv_cfg.duty_limit;
        err  = setpoint - meas;
        diff = err - last_err;
        incr = (kp * diff + ki * err) / 256;
        acc  = duty_acc + incr;
        last_err = int'(err);
        if (acc >= lim) begin
            acc = lim;
        end else if (acc <= -lim) begin
            acc = -lim;
        end
        duty_acc = int'(acc);
        if (acc >= 0) begin
            fwd_hold = DUTY_W'(acc);
            rev_hold = '0;
        end else begin
            fwd_hold = '0;
            rev_hold = DUTY_W'(-acc);
        end
    endfunction

    function automatic drive_t predict_drive(logic signed [SPEED_BITS-1:0] target,
                                             logic signed [SPEED_BITS-1:0] measured,
                                             logic stop, logic [TIME_W-1:0] run_time);
        int     x0, meas, setpoint;
        drive_t res;
        x0       = target;
        meas     = measured;
        setpoint = (7 * x0 + 2 * sp_hist0 + sp_hist1) / 10;
        sp_hist1 = sp_hist0;
        sp_hist0 = x0;
        res.written = 1'b1;
        if (stop) begin
            lamp_count++;
            if (lamp_count < int'(LAMP_MAX)) begin
                lamp_hold = 1'b1;
            end else begin
                lamp_count = int'(LAMP_MAX);
                lamp_hold  = 1'b0;
            end
            if (meas < int'(drv_cfg.stop_speed)) begin
                fwd_hold = '0;
                rev_hold = '0;
            end else begin
                pi_step(0, meas);
            end
        end else if (run_time > drv_cfg.launch_start && run_time <= drv_cfg.launch_end &&
                     meas < int'(drv_cfg.launch_speed)) begin
            fwd_hold = drv_cfg.launch_duty;
            rev_hold = '0;
        end else if (run_time > drv_cfg.launch_end) begin
            if (meas < int'(drv_cfg.launch_speed)) begin
                fwd_hold = '0;
                rev_hold = '0;
            end else begin
                pi_step(setpoint, meas);
            end
        end else begin
            res.written = 1'b0;
        end
        res.fwd  = fwd_hold;
        res.rev  = rev_hold;
        res.lamp = lamp_hold;
        return res;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PROP_GAIN:    drv_cfg.prop_gain    = data;
            CFG_INT_GAIN:     drv_cfg.int_gain     = data;
            CFG_DUTY_LIMIT:   drv_cfg.duty_limit   = data[DUTY_W-1:0];
            CFG_LAUNCH_DUTY:  drv_cfg.launch_duty  = data[DUTY_W-1:0];
            CFG_LAUNCH_START: drv_cfg.launch_start = data;
            CFG_LAUNCH_END:   drv_cfg.launch_end   = data;
            CFG_LAUNCH_SPEED: drv_cfg.launch_speed = data[THR_W-1:0];
            CFG_STOP_SPEED:   drv_cfg.stop_speed   = data[THR_W-1:0];
        endcase
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int to_speed(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function automatic t_cfg rand_cfg(setting_t kind);
        t_cfg c;
        c.prop_gain    = $urandom;
        c.int_gain     = $urandom;
        c.duty_limit   = $urandom;
        c.launch_duty  = $urandom;
        c.launch_start = $urandom;
        c.launch_end   = $urandom;
        c.launch_speed = $urandom;
        c.stop_speed   = $urandom;
        case (kind)
            SET_TYPICAL: begin
                c.prop_gain    = $urandom_range(0, 2047);
                c.int_gain     = $urandom_range(0, 511);
                c.duty_limit   = $urandom_range(500, 1023);
                c.launch_start = $urandom_range(0, 2000);
                c.launch_end   = c.launch_start + $urandom_range(1, 500);
                c.launch_speed = $urandom_range(0, 300);
                c.stop_speed   = $urandom_range(0, 100);
            end
            SET_MAXED: begin
                c = '1;
                c.launch_start = '0;
                c.launch_end   = '0;
                c.launch_speed = '0;
                c.stop_speed   = '0;
            end
            SET_ZERO: begin
                c = '0;
            end
            SET_EMPTY_WIN: begin
                c.prop_gain    = $urandom_range(0, 4095);
                c.int_gain     = $urandom_range(0, 1023);
                c.launch_start = $urandom_range(100, 60000);
                c.launch_end   = c.launch_start - $urandom_range(0, 100);
                c.launch_speed = $urandom_range(0, 400);
                c.stop_speed   = $urandom_range(0, 400);
            end
            SET_ALL_LAUNCH: begin
                c.launch_start = $urandom_range(0, 5);
                c.launch_end   = '1;
                c.launch_speed = '1;
                c.stop_speed   = '1;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    task automatic load_regs(t_cfg c, bit dirty);
        logic [CFG_DATA_W-1:0] data;
        t_cfg_idx              idx;
        idx = idx.first();
        do begin
            data = dirty ? CFG_DATA_W'($urandom) : '0;
            case (idx)
                CFG_PROP_GAIN:    data                = c.prop_gain;
                CFG_INT_GAIN:     data                = c.int_gain;
                CFG_DUTY_LIMIT:   data[DUTY_W-1:0]    = c.duty_limit;
                CFG_LAUNCH_DUTY:  data[DUTY_W-1:0]    = c.launch_duty;
                CFG_LAUNCH_START: data                = c.launch_start;
                CFG_LAUNCH_END:   data                = c.launch_end;
                CFG_LAUNCH_SPEED: data[THR_W-1:0]     = c.launch_speed;
                CFG_STOP_SPEED:   data[THR_W-1:0]     = c.stop_speed;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            apply_reg(idx, data);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(int target, int measured, logic stop, int run_time, int gap,
                             bit known, drive_t typed);
        logic signed [SPEED_BITS-1:0] tgt_v, meas_v;
        logic [TIME_W-1:0]            time_v;
        drive_t                       guess;
        tgt_v  = SPEED_BITS'(target);
        meas_v = SPEED_BITS'(measured);
        time_v = TIME_W'(run_time);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_target_speed   <= tgt_v;
        i_measured_speed <= meas_v;
        i_stop_request   <= stop;
        i_run_time       <= time_v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        guess = predict_drive(tgt_v, meas_v, stop, time_v);
        drive_queue.push_back(known ? typed : guess);
        items_sent++;
    endtask

    task automatic send_random();
        int   pick, tgt, meas, tt;
        logic stop;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            tgt = int'($urandom_range(0, 4095)) - 2048;
        end else begin
            tgt = cur_target + int'($urandom_range(0, 64)) - 32;
        end
        cur_target = to_speed(tgt);
        if (stop_burst > 0) begin
            stop = 1'b1;
            stop_burst--;
        end else if ($urandom_range(0, 11) == 0) begin
            stop = 1'b1;
            stop_burst = $urandom_range(0, 13);
        end else begin
            stop = 1'b0;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: tt = $urandom_range(0, 65535);
            3, 4:    tt = int'(drv_cfg.launch_start) + int'($urandom_range(0, 4)) - 2;
            5, 6:    tt = int'(drv_cfg.launch_end) + int'($urandom_range(0, 4)) - 2;
            7: begin
                if (drv_cfg.launch_end > drv_cfg.launch_start) begin
                    tt = $urandom_range(int'(drv_cfg.launch_start) + 1,
                                        int'(drv_cfg.launch_end));
                end else begin
                    tt = $urandom_range(0, 65535);
                end
            end
            default: tt = int'(drv_cfg.launch_end) + int'($urandom_range(1, 3000));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: meas = int'($urandom_range(0, 4095)) - 2048;
            3, 4:    meas = int'(drv_cfg.launch_speed) + int'($urandom_range(0, 6)) - 3;
            5:       meas = int'(drv_cfg.stop_speed) + int'($urandom_range(0, 6)) - 3;
            default: meas = cur_target + int'($urandom_range(0, 200)) - 100;
        endcase
        send_item(cur_target, to_speed(meas), stop, tt, in_idle_on ? idle_len() : 0,
                  1'b0, '0);
    endtask

    function automatic void check_field(string field, logic [DUTY_W-1:0] want_v,
                                        logic [DUTY_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        drive_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_queue.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual fwd %0d rev %0d wr %0b lamp %0b",
                         $time, o_forward_duty, o_reverse_duty, o_drive_written, o_lamp_on);
                errors++;
            end else begin
                want = drive_queue.pop_front();
                results_seen++;
                check_field("forward_duty", want.fwd, o_forward_duty);
                check_field("reverse_duty", want.rev, o_reverse_duty);
                check_field("drive_written", DUTY_W'(want.written), DUTY_W'(o_drive_written));
                check_field("lamp_on", DUTY_W'(want.lamp), DUTY_W'(o_lamp_on));
            end
        end
    end

    always @(posedge i_clk) begin : stall_gen
        int len;
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            len = out_stall_on ? idle_len() : 0;
            i_out_stall <= (len > 0);
            stall_left  <= (len > 0) ? len - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("motor_speed_pi_with_launch_and_stop_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int     cur_phase;
        drive_t typed;
        cur_phase = -1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].phase != cur_phase) begin
                drain();
                cur_phase = dir_rows[r].phase;
                load_regs(dir_cfg[cur_phase], 1'b0);
            end
            typed.fwd     = DUTY_W'(dir_rows[r].fwd);
            typed.rev     = DUTY_W'(dir_rows[r].rev);
            typed.written = dir_rows[r].written;
            typed.lamp    = dir_rows[r].lamp;
            send_item(dir_rows[r].target, dir_rows[r].measured, dir_rows[r].stop,
                      dir_rows[r].run_time, idle_len(), dir_rows[r].known, typed);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            load_regs(rand_cfg(plan[ph]), plan[ph] == SET_RANDOM);
            in_idle_on   = (ph % 4) != 3;
            out_stall_on = (ph % 3) != 2;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random();
            end
        end

        drain();
        $display("run covered %0d input transfers and %0d checked results", items_sent,
                 results_seen);
        $display("across %0d register settings in %0d cycles", settings_loaded, cycle_count);
        if (errors == 0 && drive_queue.size() == 0) begin
            $display("motor_speed_pi_with_launch_and_stop_core verification clean");
        end else begin
            $display("motor_speed_pi_with_launch_and_stop_core verification failed");
        end
        $finish;
    end

endmodule
